/* sv/waveform_window_downscaler_defines.svh */
// Assertion macros for the waveform window downscaler.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef WAVEFORM_WINDOW_DOWNSCALER_DEFINES_SVH
`define WAVEFORM_WINDOW_DOWNSCALER_DEFINES_SVH

// Hold expr at every edge out of reset.
`define WWD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("wwd: invariant check failed");

// Check cons from the edge at which ante holds.
`define WWD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("wwd: implication check failed");

// Check cons at the next edge after ante holds.
`define WWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("wwd: next-cycle check failed");

`endif

/* sv/wwd_pkg.sv */
// Package for the waveform window downscaler: field widths, register codes,
// reset values, and the types shared by the controller, datapath and registers.
// No dependencies.
package wwd_pkg;

    localparam int SMP_W      = 24;
    localparam int FACTOR_W   = 16;
    localparam int OUT_W      = 24;
    localparam int MODE_W     = 2;
    localparam int LEN_CFG_W  = 7;
    localparam int RECIP_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int LVL_W      = 24;
    localparam int SCALE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam int CORR_SHIFT  = 14;
    localparam int MEAN_SHIFT  = 16;
    localparam int CAL_SHIFT   = 14;
    localparam int SCALE_SHIFT = 24;

    localparam logic [MODE_W-1:0] POOL_MAX     = 2'd0;
    localparam logic [MODE_W-1:0] POOL_MAXMEAN = 2'd1;
    localparam logic [MODE_W-1:0] POOL_MEAN    = 2'd2;

    localparam logic [MODE_W-1:0]           RST_POOL_MODE  = POOL_MAX;
    localparam logic [LEN_CFG_W-1:0]        RST_WINDOW_LEN = 7'd10;
    localparam logic [RECIP_W-1:0]          RST_RECIP      = 17'd6554;
    localparam logic [GAIN_W-1:0]           RST_GAIN       = 16'd16384;
    localparam logic signed [LVL_W-1:0]     RST_LEVEL_MIN  = -24'sd1280;
    localparam logic signed [LVL_W-1:0]     RST_LEVEL_MAX  = 24'sd64000;
    localparam logic signed [LVL_W-1:0]     RST_OFFSET     = 24'sd0;
    localparam logic [SCALE_W-1:0]          RST_SCALE      = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_MODE,
        REG_WINDOW_LENGTH,
        REG_WINDOW_RECIPROCAL,
        REG_CALIB_GAIN,
        REG_LEVEL_MIN,
        REG_LEVEL_MAX,
        REG_OUT_OFFSET,
        REG_OUT_SCALE
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]    pool_mode;
        logic [LEN_CFG_W-1:0] window_length;
        logic [RECIP_W-1:0]   window_reciprocal;
        logic [GAIN_W-1:0]    calib_gain;
        logic [LVL_W-1:0]     level_min;
        logic [LVL_W-1:0]     level_max;
        logic [LVL_W-1:0]     out_offset;
        logic [SCALE_W-1:0]   out_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        RS_NONE,
        RS_AWAIT,
        RS_HELD
    } right_state_t;

    typedef enum logic [1:0] {
        SRC_MAX,
        SRC_MAXMEAN,
        SRC_MEAN
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORRECT,
        ST_UPDATE,
        ST_FINISH,
        ST_POOL1,
        ST_POOL2,
        ST_POOL3,
        ST_POOL4,
        ST_CAL1,
        ST_CAL2,
        ST_CAL3,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic correct;
        logic update;
        logic finish;
        logic pool_start;
        logic pool_is_b;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic emit_b;
        logic out_free;
    } status_t;

endpackage

/* sv/wwd_regs.sv */
// Configuration register file of the waveform window downscaler.
// Depends on wwd_pkg.
module wwd_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wwd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wwd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output wwd_pkg::cfg_t                     cfg
);
    import wwd_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_mode         <= RST_POOL_MODE;
            cfg_reg.window_length     <= RST_WINDOW_LEN;
            cfg_reg.window_reciprocal <= RST_RECIP;
            cfg_reg.calib_gain        <= RST_GAIN;
            cfg_reg.level_min         <= RST_LEVEL_MIN;
            cfg_reg.level_max         <= RST_LEVEL_MAX;
            cfg_reg.out_offset        <= RST_OFFSET;
            cfg_reg.out_scale         <= RST_SCALE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_POOL_MODE:         cfg_reg.pool_mode         <= cfg_data[MODE_W-1:0];
                REG_WINDOW_LENGTH:     cfg_reg.window_length     <= cfg_data[LEN_CFG_W-1:0];
                REG_WINDOW_RECIPROCAL: cfg_reg.window_reciprocal <= cfg_data[RECIP_W-1:0];
                REG_CALIB_GAIN:        cfg_reg.calib_gain        <= cfg_data[GAIN_W-1:0];
                REG_LEVEL_MIN:         cfg_reg.level_min         <= cfg_data[LVL_W-1:0];
                REG_LEVEL_MAX:         cfg_reg.level_max         <= cfg_data[LVL_W-1:0];
                REG_OUT_OFFSET:        cfg_reg.out_offset        <= cfg_data[LVL_W-1:0];
                REG_OUT_SCALE:         cfg_reg.out_scale         <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

endmodule

/* sv/wwd_ctrl.sv */
// Sequencer of the waveform window downscaler: steps each sample through
// correction, window update and up to two result passes. Depends on wwd_pkg.
module wwd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  wwd_pkg::status_t st,
    output wwd_pkg::cmd_t    cmd
);
    import wwd_pkg::*;

    state_t state_reg, state_next;
    logic   phase_b_reg, phase_b_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_b_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_b_reg <= phase_b_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_b_next  = phase_b_reg;
        cmd           = '0;
        cmd.pool_is_b = phase_b_reg;
        item_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CORRECT;
                end
            end
            ST_CORRECT:
            begin
                cmd.correct = 1'b1;
                if (st.pending)
                begin
                    phase_b_next = 1'b0;
                    state_next   = ST_POOL1;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (st.emit_b)
                begin
                    phase_b_next = 1'b1;
                    state_next   = ST_POOL1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_POOL1:
            begin
                cmd.pool_start = 1'b1;
                state_next     = ST_POOL2;
            end
            ST_POOL2: state_next = ST_POOL3;
            ST_POOL3: state_next = ST_POOL4;
            ST_POOL4: state_next = ST_CAL1;
            ST_CAL1:  state_next = ST_CAL2;
            ST_CAL2:  state_next = ST_CAL3;
            ST_CAL3:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (st.out_free)
                begin
                    state_next = phase_b_reg ? ST_FINISH : ST_UPDATE;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

endmodule

/* sv/wwd_dp.sv */
// Datapath of the waveform window downscaler: sample correction, window state,
// pooling, calibration chain and result register. Depends on wwd_pkg.
module wwd_dp #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wwd_pkg::cfg_t                       cfg,
    input  wwd_pkg::cmd_t                       cmd,
    output wwd_pkg::status_t                    st,
    input  logic signed [wwd_pkg::SMP_W-1:0]    sample,
    input  logic [wwd_pkg::FACTOR_W-1:0]        lifetime_factor,
    input  logic                                last_sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [wwd_pkg::OUT_W-1:0]    pooled_value,
    output logic                                last_result
);
    import wwd_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int WIDE   = 64;
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam int SUM_W  = SB + POS_W;
    localparam int PROD_W = SMP_W + FACTOR_W + 1;
    localparam int MEAN_W = SUM_W + RECIP_W + 1;
    localparam int MM_W   = SB + 2;
    localparam int MAG_W  = SB + 1;
    localparam int DM_W   = MAG_W - 1;
    localparam int DP_W   = MAG_W + DM_W;
    localparam int CALP_W = SB + GAIN_W + 1;
    localparam int CAL_W  = CALP_W - CAL_SHIFT;
    localparam int CLP_W  = (CAL_W > LVL_W) ? CAL_W : LVL_W;
    localparam int DIFF_W = LVL_W + 1;
    localparam int SCL_W  = DIFF_W + SCALE_W + 1;

    localparam logic [DM_W-1:0] DIV3_M = DM_W'((WIDE'(1) << MAG_W) / 3);
    localparam logic signed [WIDE-1:0] SB_HI  = (WIDE'(1) << (SB - 1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] SB_LO  = -SB_HI - WIDE'(1);
    localparam logic signed [WIDE-1:0] OUT_HI = (WIDE'(1) << (OUT_W - 1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] OUT_LO = -OUT_HI - WIDE'(1);

    function automatic logic signed [SB-1:0] sat_sb(input logic signed [WIDE-1:0] v);
        if (v > SB_HI)
            return SB'(SB_HI);
        if (v < SB_LO)
            return SB'(SB_LO);
        return SB'(v);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE-1:0] v);
        if (v > OUT_HI)
            return OUT_W'(OUT_HI);
        if (v < OUT_LO)
            return OUT_W'(OUT_LO);
        return OUT_W'(v);
    endfunction

    // window state
    logic signed [PROD_W-1:0] prod_reg;
    logic                     last_reg;
    logic signed [SB-1:0]     c_reg, c_next;
    logic [POS_W-1:0]         pos_reg;
    logic signed [SB-1:0]     max_reg, prev_reg, left_reg, right_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     prev_valid_reg, left_present_reg, pending_reg;
    right_state_t             right_state_reg;

    // pooling and calibration stages
    src_t                     src_reg, b_src;
    logic                     res_last_reg;
    logic signed [MEAN_W-1:0] mean_prod_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [1:0]               n_reg;
    logic [DP_W-1:0]          div_prod_reg;
    logic [MAG_W-1:0]         q_reg;
    logic signed [SB-1:0]     pooled_reg;
    logic signed [CALP_W-1:0] cal_prod_reg;
    logic signed [LVL_W-1:0]  clamped_reg;
    logic signed [SCL_W-1:0]  scale_prod_reg;

    // result register
    logic                     result_valid_reg;
    logic signed [OUT_W-1:0]  pooled_value_reg;
    logic                     last_result_reg;

    logic [CMP_W-1:0]         len_ext, eff_len, pos_inc;
    logic                     completes, newmax, out_free;
    logic signed [MM_W-1:0]   mm_sum;
    logic [1:0]               mm_n;
    logic [MAG_W-1:0]         q0;
    logic [MAG_W+1:0]         q0_x3, rem;
    logic [MAG_W-1:0]         q3;
    logic signed [SB-1:0]     q_sb;
    logic signed [CLP_W-1:0]  cal_w, lo_w, hi_w, clamp_lo;
    logic signed [DIFF_W-1:0] diff;

    assign c_next = sat_sb(WIDE'(prod_reg >>> CORR_SHIFT));

    always_comb
    begin
        len_ext = CMP_W'(cfg.window_length);
        if (len_ext == '0)
            eff_len = CMP_W'(1);
        else if (len_ext > CMP_W'(MAX_WINDOW))
            eff_len = CMP_W'(MAX_WINDOW);
        else
            eff_len = len_ext;
        pos_inc   = CMP_W'(pos_reg) + CMP_W'(1);
        completes = (pos_inc >= eff_len);
        newmax    = (pos_reg == '0) || (c_reg > max_reg);
        sum_next  = (pos_reg == '0) ? SUM_W'(c_reg) : sum_reg + SUM_W'(c_reg);
        if (cfg.pool_mode == POOL_MEAN)
            b_src = SRC_MEAN;
        else if (cfg.pool_mode == POOL_MAXMEAN)
            b_src = SRC_MAXMEAN;
        else
            b_src = SRC_MAX;
    end

    assign out_free    = !result_valid_reg || result_ready;
    assign st.pending  = pending_reg;
    assign st.emit_b   = completes && ((cfg.pool_mode != POOL_MAXMEAN) || last_reg);
    assign st.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg         <= '0;
            last_reg         <= 1'b0;
            c_reg            <= '0;
            pos_reg          <= '0;
            max_reg          <= '0;
            sum_reg          <= '0;
            prev_reg         <= '0;
            prev_valid_reg   <= 1'b0;
            left_reg         <= '0;
            left_present_reg <= 1'b0;
            right_reg        <= '0;
            right_state_reg  <= RS_NONE;
            pending_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prod_reg <= sample * $signed({1'b0, lifetime_factor});
                last_reg <= last_sample;
            end
            if (cmd.correct)
            begin
                c_reg <= c_next;
                if (right_state_reg == RS_AWAIT)
                begin
                    right_reg       <= c_next;
                    right_state_reg <= RS_HELD;
                end
            end
            if (cmd.update)
            begin
                sum_reg <= sum_next;
                if (newmax)
                begin
                    max_reg          <= c_reg;
                    left_reg         <= prev_reg;
                    left_present_reg <= prev_valid_reg;
                    right_state_reg  <= RS_AWAIT;
                end
                prev_reg       <= c_reg;
                prev_valid_reg <= 1'b1;
                pos_reg        <= completes ? '0 : pos_inc[POS_W-1:0];
                pending_reg    <= completes && (cfg.pool_mode == POOL_MAXMEAN) && !last_reg;
            end
            if (cmd.finish && last_reg)
            begin
                pos_reg         <= '0;
                prev_valid_reg  <= 1'b0;
                right_state_reg <= RS_NONE;
                pending_reg     <= 1'b0;
            end
        end
    end

    always_comb
    begin
        mm_sum = MM_W'(max_reg);
        mm_n   = 2'd1;
        if (left_present_reg)
        begin
            mm_sum = mm_sum + MM_W'(left_reg);
            mm_n   = mm_n + 2'd1;
        end
        if (right_state_reg == RS_HELD)
        begin
            mm_sum = mm_sum + MM_W'(right_reg);
            mm_n   = mm_n + 2'd1;
        end
        q0    = div_prod_reg[DP_W-1:MAG_W];
        q0_x3 = (MAG_W+2)'(q0) + ((MAG_W+2)'(q0) << 1);
        rem   = (MAG_W+2)'(mag_reg) - q0_x3;
        q3    = (rem >= (MAG_W+2)'(3)) ? q0 + MAG_W'(1) : q0;
        q_sb  = SB'(q_reg);
        cal_w = CLP_W'(cal_prod_reg >>> CAL_SHIFT);
        lo_w  = CLP_W'($signed(cfg.level_min));
        hi_w  = CLP_W'($signed(cfg.level_max));
        clamp_lo = (cal_w < lo_w) ? lo_w : cal_w;
        diff  = DIFF_W'(clamped_reg) - DIFF_W'($signed(cfg.level_min));
    end

    // stages run every cycle; the sequencer holds their sources steady
    always_ff @(posedge clk)
    begin
        if (cmd.pool_start)
        begin
            src_reg      <= cmd.pool_is_b ? b_src : SRC_MAXMEAN;
            res_last_reg <= cmd.pool_is_b ? last_reg : (last_reg && !completes);
        end
        mean_prod_reg <= sum_reg * $signed({1'b0, cfg.window_reciprocal});
        neg_reg       <= mm_sum[MM_W-1];
        mag_reg       <= mm_sum[MM_W-1] ? MAG_W'(-mm_sum) : MAG_W'(mm_sum);
        n_reg         <= mm_n;
        div_prod_reg  <= mag_reg * DIV3_M;
        unique case (n_reg)
            2'd1:    q_reg <= mag_reg;
            2'd2:    q_reg <= mag_reg >> 1;
            default: q_reg <= q3;
        endcase
        unique case (src_reg)
            SRC_MEAN:    pooled_reg <= sat_sb(WIDE'(mean_prod_reg >>> MEAN_SHIFT));
            SRC_MAXMEAN: pooled_reg <= neg_reg ? -q_sb : q_sb;
            default:     pooled_reg <= max_reg;
        endcase
        cal_prod_reg   <= pooled_reg * $signed({1'b0, cfg.calib_gain});
        clamped_reg    <= LVL_W'((clamp_lo > hi_w) ? hi_w : clamp_lo);
        scale_prod_reg <= diff * $signed({1'b0, cfg.out_scale});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && out_free)
        begin
            pooled_value_reg <= sat_out(WIDE'($signed(cfg.out_offset))
                                        + WIDE'(scale_prod_reg >>> SCALE_SHIFT));
            last_result_reg  <= res_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign pooled_value = pooled_value_reg;
    assign last_result  = last_result_reg;

endmodule

/* sv/waveform_window_downscaler.sv */
// Top level of the waveform window downscaler: configuration registers,
// sequencer and datapath. Depends on wwd_pkg, wwd_regs, wwd_ctrl, wwd_dp and
// the assertion macros in waveform_window_downscaler_defines.svh.
//
// Each sample is multiplied by its lifetime factor and pooled over windows of
// window_length samples (max, max with neighbour mean, or mean), then each
// pooled value is calibrated, clamped, offset and scaled into one transfer on
// the result channel. A new sample is taken only in the idle state, after the
// previous one has run its correct, update and finish steps and each of its
// results has run through the pooling and calibration multiplier chain (up to
// two results per sample) and any wait of the emit state on result_ready. The
// result register lets the next sample be taken while a finished result is
// still waiting. Configuration writes are taken in every cycle and are to be
// issued while the block is idle.
`include "waveform_window_downscaler_defines.svh"

module waveform_window_downscaler #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [wwd_pkg::SMP_W-1:0]   sample,
    input  logic [wwd_pkg::FACTOR_W-1:0]       lifetime_factor,
    input  logic                               last_sample,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [wwd_pkg::OUT_W-1:0]   pooled_value,
    output logic                               last_result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wwd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wwd_pkg::*;

    cfg_t       cfg;
    cmd_t       cmd;
    status_t    st;
    logic [5:0] cmd_bits;

    wwd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wwd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    wwd_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .st              (st),
        .sample          (sample),
        .lifetime_factor (lifetime_factor),
        .last_sample     (last_sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .pooled_value    (pooled_value),
        .last_result     (last_result)
    );

    assign cmd_bits = {cmd.load, cmd.correct, cmd.update, cmd.finish, cmd.pool_start, cmd.emit};

    `WWD_ASSERT_ALWAYS(a_one_command, $onehot0(cmd_bits))
    `WWD_ASSERT_NEXT(a_accept_then_correct, item_valid && item_ready, cmd.correct)
    `WWD_ASSERT_IMPLIES(a_pool_latency, cmd.pool_start, ##7 cmd.emit)
    `WWD_ASSERT_IMPLIES(a_result_from_emit, $rose(result_valid), $past(cmd.emit))

endmodule
